// ===== sv/act_pkg.sv =====
package act_pkg;

    // Fixed field widths of the collider word.
    localparam int ID_W     = 16;
    localparam int DIM_W    = 15;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 2;

    // Command codes carried by an input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_UPDATE = 2'd3
    } cmd_t;

    // Status codes carried by a result word.
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_HIT       = 3'd5,
        ST_NO_HIT    = 3'd6,
        ST_UPDATED   = 3'd7
    } status_t;

    // Outcome of comparing the held query against one stored entry.
    typedef struct packed {
        logic id_match;
        logic hit;
    } cmp_t;

endpackage

// ===== sv/act_ram.sv =====
module act_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/act_ovl.sv =====
module act_ovl #(
    parameter int COORD_BITS = 16
) (
    input  logic [act_pkg::ID_W-1:0]  q_id,
    input  logic signed [COORD_BITS-1:0] q_left,
    input  logic signed [COORD_BITS-1:0] q_top,
    input  logic [act_pkg::DIM_W-1:0] q_width,
    input  logic [act_pkg::DIM_W-1:0] q_height,
    input  logic                      q_proj,
    input  logic [act_pkg::ID_W-1:0]  e_id,
    input  logic signed [COORD_BITS-1:0] e_left,
    input  logic signed [COORD_BITS-1:0] e_top,
    input  logic [act_pkg::DIM_W-1:0] e_width,
    input  logic [act_pkg::DIM_W-1:0] e_height,
    input  logic                      e_proj,
    output act_pkg::cmp_t             res
);

    // Edges are formed wide enough that left plus width never wraps.
    localparam int SUM_W = ((COORD_BITS > act_pkg::DIM_W) ? COORD_BITS : act_pkg::DIM_W) + 2;

    logic signed [SUM_W-1:0] ql, qt, qr, qb;
    logic signed [SUM_W-1:0] el, et, er, eb;
    logic signed [SUM_W-1:0] qw, qh, ew, eh;
    logic                    overlap;

    // Extend edges and sizes, then form the right and bottom edges.
    always_comb
    begin
        ql = SUM_W'(q_left);
        qt = SUM_W'(q_top);
        el = SUM_W'(e_left);
        et = SUM_W'(e_top);
        qw = SUM_W'(q_width);
        qh = SUM_W'(q_height);
        ew = SUM_W'(e_width);
        eh = SUM_W'(e_height);
        qr = ql + qw;
        qb = qt + qh;
        er = el + ew;
        eb = et + eh;
    end

    // Strict overlap on both axes.
    assign overlap = (ql < er) && (qr > el) && (qt < eb) && (qb > et);

    // A hit skips the query's own id and projectile pairs.
    assign res.id_match = (q_id == e_id);
    assign res.hit      = overlap && (q_id != e_id) && !(q_proj && e_proj);

endmodule

// ===== sv/aabb_collider_table_top.sv =====
// Channel  Handshake             Words carried
// -------  --------------------  ------------------------------------------------
// req      req_valid/req_stall   cmd, collider_id, left_x, top_y, rect_width,
//                                rect_height, is_projectile
// rsp      rsp_valid/rsp_stall   status, other_id, last
//
// The table sits in one RAM with a registered read port, and one entry is
// visited per cycle unless rsp stalls. Add, update and check keep req stalled
// until their final word is loaded, and an add or update that meets its id
// ends its search early; remove searches and then shifts later entries down.
// Hits leave one word per cycle while the scan runs, and so do not slow the scan unless rsp stalls.
// Reset clears the entry count and control state only; table contents are
// never cleared. A stalled rsp channel holds the scan and the final word, and
// req is stalled while a word is being worked.
module aabb_collider_table_top #(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [act_pkg::CMD_W-1:0]       cmd,
    input  logic [act_pkg::ID_W-1:0]        collider_id,
    input  logic signed [COORD_BITS-1:0]    left_x,
    input  logic signed [COORD_BITS-1:0]    top_y,
    input  logic [act_pkg::DIM_W-1:0]       rect_width,
    input  logic [act_pkg::DIM_W-1:0]       rect_height,
    input  logic                            is_projectile,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [act_pkg::STATUS_W-1:0]    status,
    output logic [act_pkg::ID_W-1:0]        other_id,
    output logic                            last
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W  = act_pkg::ID_W;
    localparam int DIM_W = act_pkg::DIM_W;
    localparam int ENT_W = ID_W + 2 * COORD_BITS + 2 * DIM_W + 1;

    // Field positions inside one stored entry.
    localparam int H_LO   = 1;
    localparam int W_LO   = H_LO + DIM_W;
    localparam int TOP_LO = W_LO + DIM_W;
    localparam int LFT_LO = TOP_LO + COORD_BITS;
    localparam int ID_LO  = LFT_LO + COORD_BITS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIND  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_SCAN  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]          pend_id_reg, pend_id_next;
    act_pkg::status_t         resp_status_reg, resp_status_next;

    act_pkg::cmd_t            q_cmd_reg;
    logic [ID_W-1:0]          q_id_reg;
    logic signed [COORD_BITS-1:0] q_left_reg, q_top_reg;
    logic [DIM_W-1:0]         q_w_reg, q_h_reg;
    logic                     q_proj_reg;

    logic                     out_valid_reg, out_valid_next;
    act_pkg::status_t         out_status_reg, out_status_next;
    logic [ID_W-1:0]          out_id_reg, out_id_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_load, out_free;

    logic                     req_accept, at_end;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [ENT_W-1:0]         wr_data, rd_data, new_entry;
    act_pkg::cmp_t            cmp;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !out_valid_reg || !rsp_stall;
    assign at_end     = (ptr_reg >= count_reg);
    assign new_entry  = {q_id_reg, q_left_reg, q_top_reg, q_w_reg, q_h_reg, q_proj_reg};

    // Entry storage; the read address follows the scan pointer's next value.
    act_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_next[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Shared compare unit for id search and overlap test.
    act_ovl #(
        .COORD_BITS (COORD_BITS)
    ) u_ovl (
        .q_id     (q_id_reg),
        .q_left   (q_left_reg),
        .q_top    (q_top_reg),
        .q_width  (q_w_reg),
        .q_height (q_h_reg),
        .q_proj   (q_proj_reg),
        .e_id     (rd_data[ENT_W-1:ID_LO]),
        .e_left   (rd_data[ID_LO-1:LFT_LO]),
        .e_top    (rd_data[LFT_LO-1:TOP_LO]),
        .e_width  (rd_data[TOP_LO-1:W_LO]),
        .e_height (rd_data[W_LO-1:H_LO]),
        .e_proj   (rd_data[0]),
        .res      (cmp)
    );

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        resp_status_next = resp_status_reg;
        wr_en            = 1'b0;
        wr_addr          = ptr_reg[IDX_W-1:0];
        wr_data          = new_entry;
        out_load         = 1'b0;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    ptr_next        = '0;
                    pend_valid_next = 1'b0;
                    if (act_pkg::cmd_t'(cmd) == act_pkg::CMD_CHECK)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FIND;
                    end
                end
            end

            S_FIND:
            begin
                if (at_end)
                begin
                    state_next = S_RESP;
                    unique case (q_cmd_reg) inside
                        act_pkg::CMD_ADD:
                        begin
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                resp_status_next = act_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                wr_addr          = count_reg[IDX_W-1:0];
                                count_next       = count_reg + CNT_W'(1);
                                resp_status_next = act_pkg::ST_ADDED;
                            end
                        end
                        act_pkg::CMD_REMOVE, act_pkg::CMD_UPDATE, act_pkg::CMD_CHECK:
                        begin
                            resp_status_next = act_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
                else if (cmp.id_match)
                begin
                    unique case (q_cmd_reg) inside
                        act_pkg::CMD_ADD, act_pkg::CMD_CHECK:
                        begin
                            resp_status_next = act_pkg::ST_PRESENT;
                            state_next       = S_RESP;
                        end
                        act_pkg::CMD_UPDATE:
                        begin
                            wr_en            = 1'b1;
                            resp_status_next = act_pkg::ST_UPDATED;
                            state_next       = S_RESP;
                        end
                        act_pkg::CMD_REMOVE:
                        begin
                            ptr_next   = ptr_reg + CNT_W'(1);
                            state_next = S_SHIFT;
                        end
                    endcase
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end

            // Close the gap: entry at ptr moves down one slot.
            S_SHIFT:
            begin
                if (at_end)
                begin
                    count_next       = count_reg - CNT_W'(1);
                    resp_status_next = act_pkg::ST_REMOVED;
                    state_next       = S_RESP;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = ptr_reg[IDX_W-1:0] - IDX_W'(1);
                    wr_data  = rd_data;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end

            // A hit is held until the next one shows it is not the final word.
            S_SCAN:
            begin
                if (at_end)
                begin
                    resp_status_next = pend_valid_reg ? act_pkg::ST_HIT : act_pkg::ST_NO_HIT;
                    state_next       = S_RESP;
                end
                else if (cmp.hit)
                begin
                    if (!pend_valid_reg)
                    begin
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_data[ENT_W-1:ID_LO];
                        ptr_next        = ptr_reg + CNT_W'(1);
                    end
                    else if (out_free)
                    begin
                        out_load        = 1'b1;
                        out_status_next = act_pkg::ST_HIT;
                        out_id_next     = pend_id_reg;
                        out_last_next   = 1'b0;
                        pend_id_next    = rd_data[ENT_W-1:ID_LO];
                        ptr_next        = ptr_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = resp_status_reg;
                    out_id_next     = (resp_status_reg == act_pkg::ST_HIT) ? pend_id_reg : '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && rsp_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_id_reg     <= pend_id_next;
        resp_status_reg <= resp_status_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_last_reg    <= out_last_next;
        if (req_accept)
        begin
            q_cmd_reg  <= act_pkg::cmd_t'(cmd);
            q_id_reg   <= collider_id;
            q_left_reg <= left_x;
            q_top_reg  <= top_y;
            q_w_reg    <= rect_width;
            q_h_reg    <= rect_height;
            q_proj_reg <= is_projectile;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign other_id  = out_id_reg;
    assign last      = out_last_reg;

    // The fill count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // Only hit words can be followed by more words of the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_status_reg == act_pkg::ST_HIT))
        else $error("non-final word without hit status");

    // A finished removal drops the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && state_next == S_RESP)
        |=> (count_reg + CNT_W'(1) == $past(count_reg)))
        else $error("removal did not shrink the table by one");

    // A pending hit only exists during a scan, its final word, or the idle time after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_SCAN || state_reg == S_RESP
                            || state_reg == S_IDLE))
        else $error("pending hit outside a check");

endmodule
